[design/rsmd_pkg.sv]
// ----------------------------------------------------------------------------
// rsmd_pkg
// Shared types and constants for the ray/segment minimum distance block.
// ----------------------------------------------------------------------------
package rsmd_pkg;

  localparam logic [24:0] DIST_MAX = 25'h1FF_FFFF;

  localparam int SQ_STEPS  = 25;
  localparam int DIV_STEPS = 65;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_DIR_X    = 3'd2,
    REG_DIR_Y    = 3'd3,
    REG_DET_EPS  = 3'd4,
    REG_COEF_TOL = 3'd5,
    REG_RSVD6    = 3'd6,
    REG_RSVD7    = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DET0, ST_DET1, ST_DET2,
    ST_COL0, ST_COL1,
    ST_NA0,  ST_NA1,
    ST_EVAL,
    ST_TD0,  ST_TD1,  ST_TD2,
    ST_COEF,
    ST_MS0,  ST_MS1,  ST_MS2, ST_MSQ,
    ST_DM0,  ST_DM1,  ST_DM2, ST_DIV,
    ST_LA0,  ST_LA1,  ST_LA2, ST_LAQ,
    ST_LB0,  ST_LB1,  ST_LB2, ST_LBQ,
    ST_DONE
  } st_t;

endpackage

[design/rsmd_mul.sv]
// ----------------------------------------------------------------------------
// rsmd_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rsmd_mul (
  input  logic               clk,
  input  logic signed [26:0] a,
  input  logic signed [26:0] b,
  output logic signed [53:0] prod
);
  always_ff @(posedge clk) begin
    prod <= a * b;
  end
endmodule

[design/rsmd_sqrt.sv]
// ----------------------------------------------------------------------------
// rsmd_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rsmd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [49:0] operand,
  output logic        done,
  output logic [24:0] root
);
  import rsmd_pkg::*;

  logic [49:0] x;
  logic [49:0] r;
  logic [49:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [50:0] trial;

  assign trial = {1'b0, r} + {1'b0, bitv};
  assign root  = r[24:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'(SQ_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= operand;
      r    <= '0;
      bitv <= 50'd1 << 48;
      cnt  <= '0;
    end else if (busy) begin
      if ({1'b0, x} >= trial) begin
        x <= x - trial[49:0];
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + 5'd1;
    end
  end
endmodule

[design/rsmd_div.sv]
// ----------------------------------------------------------------------------
// rsmd_div
// Restoring divider, one quotient bit per cycle, saturating 25 bit quotient.
// ----------------------------------------------------------------------------
module rsmd_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [64:0] num,
  input  logic [41:0] den,
  output logic        done,
  output logic [24:0] quot
);
  import rsmd_pkg::*;

  logic [64:0] n;
  logic [41:0] d;
  logic [41:0] rem;
  logic [24:0] q;
  logic        ovf;
  logic [6:0]  cnt;
  logic        busy;
  logic [41:0] sh;
  logic        ge;

  assign sh   = {rem[40:0], n[64]};
  assign ge   = sh >= d;
  assign quot = ovf ? DIST_MAX : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 7'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n   <= num;
      d   <= den;
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? sh - d : sh;
      n   <= n << 1;
      // quotient past 25 bits only matters as saturation
      q   <= {q[23:0], ge};
      ovf <= ovf | q[24];
      cnt <= cnt + 7'd1;
    end
  end
endmodule

[design/ray_segment_min_distance.sv]
// ----------------------------------------------------------------------------
// ray_segment_min_distance
// Ray cast against a stream of segments, keeping the nearest hit distance.
// ----------------------------------------------------------------------------
// One segment transaction is taken at a time; seg_stall stays high until it
// is finished. A degenerate hit runs two 25-step square roots, and a regular
// hit a 25-step square root of the direction length followed by a 65-step
// restoring divide, all sharing one registered 27x27 multiplier. A segment
// flagged last_segment emits one result transaction; if the previous result
// is still stalled the block waits for it. hit_found low means distance reads
// all ones.
// ----------------------------------------------------------------------------
module ray_segment_min_distance (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        seg_valid,
  output logic        seg_stall,
  input  logic [23:0] seg_ax,
  input  logic [23:0] seg_ay,
  input  logic [23:0] seg_bx,
  input  logic [23:0] seg_by,
  input  logic        last_segment,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [24:0] distance,
  output logic        hit_found
);
  import rsmd_pkg::*;

  // configuration
  logic [23:0] origin_x, origin_y;
  logic [15:0] dir_x, dir_y, det_epsilon, coef_tolerance;
  reg_idx_t    ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= '0;
      origin_y       <= '0;
      dir_x          <= 16'd16384;
      dir_y          <= '0;
      det_epsilon    <= 16'd16;
      coef_tolerance <= 16'd16;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_ORIGIN_X: origin_x       <= pwdata[23:0];
        REG_ORIGIN_Y: origin_y       <= pwdata[23:0];
        REG_DIR_X:    dir_x          <= pwdata[15:0];
        REG_DIR_Y:    dir_y          <= pwdata[15:0];
        REG_DET_EPS:  det_epsilon    <= pwdata[15:0];
        REG_COEF_TOL: coef_tolerance <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ORIGIN_X: prdata = {8'd0, origin_x};
      REG_ORIGIN_Y: prdata = {8'd0, origin_y};
      REG_DIR_X:    prdata = {16'd0, dir_x};
      REG_DIR_Y:    prdata = {16'd0, dir_y};
      REG_DET_EPS:  prdata = {16'd0, det_epsilon};
      REG_COEF_TOL: prdata = {16'd0, coef_tolerance};
      default:      prdata = '0;
    endcase
  end

  // datapath registers
  st_t                state, state_next;
  logic signed [24:0] vax, vay, vbx, vby;
  logic               lastq;
  logic signed [53:0] tmp;
  logic signed [50:0] det;
  logic signed [41:0] col;   // also the second basis numerator
  logic signed [41:0] na;
  logic [49:0]        dmag;
  logic [66:0]        td;
  logic [41:0]        ssum;
  logic [24:0]        m;
  logic [24:0]        best;
  logic               any_hit;

  logic signed [26:0] mul_a, mul_b;
  logic signed [53:0] prod;
  logic               sq_start, sq_done, dv_start, dv_done;
  logic [24:0]        sq_root, dv_quot;
  logic [49:0]        sq_op;
  logic [64:0]        dv_num;

  logic signed [15:0] dxs, dys;
  logic signed [50:0] det_neg;
  logic [49:0]        dmag_c;
  logic [40:0]        colmag;
  logic               degen, col_ok;
  logic signed [41:0] na_n, nb_n;
  logic signed [42:0] s_c;
  logic               na_ok, nb_ok;
  logic               take_en;
  logic [24:0]        take_dist;
  logic               accept, out_free;

  assign dxs = signed'(dir_x);
  assign dys = signed'(dir_y);

  assign det_neg = -det;
  assign dmag_c  = det[50] ? det_neg[49:0] : det[49:0];
  assign colmag  = col[41] ? 41'(-col) : col[40:0];
  assign degen   = (det == '0) || (dmag_c < {34'd0, det_epsilon});
  assign col_ok  = (col == '0) || (colmag < {25'd0, det_epsilon});

  // normalized numerators already stored after eval
  assign na_ok = (na > 0) || ((td != '0) && ((td[66:52] != '0) ||
                 ({1'b0, 41'(-na), 10'd0} <= 52'(td))));
  assign nb_ok = (col > 0) || ((td != '0) && ((td[66:52] != '0) ||
                 ({1'b0, 41'(-col), 10'd0} <= 52'(td))));
  assign s_c   = 43'(na) + 43'(col);
  assign na_n  = det[50] ? -na : na;
  assign nb_n  = det[50] ? -col : col;

  assign sq_op  = 50'(tmp) + 50'(prod);
  assign dv_num = {prod[38:0], 26'd0} + {11'd0, tmp};

  assign accept   = seg_valid && !seg_stall;
  assign out_free = !res_valid || !res_stall;
  assign seg_stall = (state != ST_IDLE);

  rsmd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  rsmd_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .operand(sq_op),
    .done(sq_done), .root(sq_root)
  );

  rsmd_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(ssum),
    .done(dv_done), .quot(dv_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    sq_start   = 1'b0;
    dv_start   = 1'b0;
    take_en    = 1'b0;
    take_dist  = sq_root;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_DET0;
      ST_DET0: begin mul_a = 27'(vax); mul_b = 27'(vby); state_next = ST_DET1; end
      ST_DET1: begin mul_a = 27'(vbx); mul_b = 27'(vay); state_next = ST_DET2; end
      ST_DET2: begin mul_a = 27'(vax); mul_b = 27'(dys); state_next = ST_COL0; end
      ST_COL0: begin mul_a = 27'(vay); mul_b = 27'(dxs); state_next = ST_COL1; end
      ST_COL1: begin mul_a = 27'(vby); mul_b = 27'(dxs); state_next = ST_NA0; end
      ST_NA0:  begin mul_a = 27'(vbx); mul_b = 27'(dys); state_next = ST_NA1; end
      ST_NA1:  state_next = ST_EVAL;
      ST_EVAL: begin
        if (!degen)      state_next = ST_TD0;
        else if (col_ok) state_next = ST_LA0;
        else             state_next = ST_DONE;
      end
      ST_TD0: begin
        mul_a = 27'(signed'({1'b0, coef_tolerance}));
        mul_b = 27'(signed'({1'b0, dmag[25:0]}));
        state_next = ST_TD1;
      end
      ST_TD1: begin
        mul_a = 27'(signed'({1'b0, coef_tolerance}));
        mul_b = 27'(signed'({1'b0, dmag[49:26]}));
        state_next = ST_TD2;
      end
      ST_TD2: state_next = ST_COEF;
      ST_COEF: begin
        if (na_ok && nb_ok && s_c > 0) state_next = ST_MS0;
        else                           state_next = ST_DONE;
      end
      ST_MS0: begin mul_a = 27'(dxs); mul_b = 27'(dxs); state_next = ST_MS1; end
      ST_MS1: begin mul_a = 27'(dys); mul_b = 27'(dys); state_next = ST_MS2; end
      ST_MS2: begin sq_start = 1'b1; state_next = ST_MSQ; end
      ST_MSQ: if (sq_done) state_next = ST_DM0;
      ST_DM0: begin
        mul_a = 27'(signed'({1'b0, dmag[25:0]}));
        mul_b = 27'(signed'({1'b0, m}));
        state_next = ST_DM1;
      end
      ST_DM1: begin
        mul_a = 27'(signed'({1'b0, dmag[49:26]}));
        mul_b = 27'(signed'({1'b0, m}));
        state_next = ST_DM2;
      end
      ST_DM2: begin dv_start = 1'b1; state_next = ST_DIV; end
      ST_DIV: begin
        take_dist = dv_quot;
        if (dv_done) begin
          take_en    = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_LA0: begin mul_a = 27'(vax); mul_b = 27'(vax); state_next = ST_LA1; end
      ST_LA1: begin mul_a = 27'(vay); mul_b = 27'(vay); state_next = ST_LA2; end
      ST_LA2: begin sq_start = 1'b1; state_next = ST_LAQ; end
      ST_LAQ: if (sq_done) state_next = ST_LB0;
      ST_LB0: begin mul_a = 27'(vbx); mul_b = 27'(vbx); state_next = ST_LB1; end
      ST_LB1: begin mul_a = 27'(vby); mul_b = 27'(vby); state_next = ST_LB2; end
      ST_LB2: begin sq_start = 1'b1; state_next = ST_LBQ; end
      ST_LBQ: begin
        take_dist = (m < sq_root) ? m : sq_root;
        if (sq_done) begin
          take_en    = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: if (!lastq || out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vax   <= 25'(signed'(seg_ax)) - 25'(signed'(origin_x));
      vay   <= 25'(signed'(seg_ay)) - 25'(signed'(origin_y));
      vbx   <= 25'(signed'(seg_bx)) - 25'(signed'(origin_x));
      vby   <= 25'(signed'(seg_by)) - 25'(signed'(origin_y));
      lastq <= last_segment;
    end
    unique case (state)
      ST_DET1, ST_COL0, ST_NA0, ST_TD1, ST_MS1, ST_DM1, ST_LA1, ST_LB1: tmp <= prod;
      ST_DET2: det <= 51'(tmp - prod);
      ST_COL1: col <= 42'(tmp - prod);
      ST_NA1:  na  <= 42'(tmp - prod);
      ST_EVAL: begin
        dmag <= dmag_c;
        na   <= na_n;
        col  <= nb_n;
      end
      ST_TD2:  td   <= {prod[40:0], 26'd0} + {13'd0, tmp};
      ST_COEF: ssum <= s_c[41:0];
      ST_MSQ, ST_LAQ: if (sq_done) m <= sq_root;
      default: ;
    endcase
  end

  // running minimum and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      best      <= DIST_MAX;
      any_hit   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && lastq && out_free) begin
        res_valid <= 1'b1;
        best      <= DIST_MAX;
        any_hit   <= 1'b0;
      end else begin
        if (res_valid && !res_stall) res_valid <= 1'b0;
        if (take_en) begin
          if (take_dist < best) best <= take_dist;
          any_hit <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && lastq && out_free) begin
      distance  <= best;
      hit_found <= any_hit;
    end
  end
endmodule

[design/rsmd_checker.sv]
// ----------------------------------------------------------------------------
// rsmd_checker
// Port level checks for the ray/segment minimum distance block.
// ----------------------------------------------------------------------------
module rsmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        seg_valid,
  input logic        seg_stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic [24:0] distance,
  input logic        hit_found,
  input logic        pready
);
  import rsmd_pkg::*;

  // a stalled result transaction holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(distance) && $stable(hit_found))
    else $error("result changed while stalled");

  // a miss reports saturated distance
  a_miss_dist: assert property (@(posedge clk) disable iff (rst)
    res_valid && !hit_found |-> distance == DIST_MAX)
    else $error("miss with distance not saturated");

  // a segment transaction is not accepted back to back
  a_busy: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_stall |=> seg_stall)
    else $error("segment accepted back to back");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");
endmodule

bind ray_segment_min_distance rsmd_checker u_rsmd_checker (.*);

[tb/sv/ray_segment_min_distance_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_segment_min_distance_test
// Sends segment queries through the block under a range of ray settings and
// checks each emitted minimum distance and hit flag against a local predictor.
// ----------------------------------------------------------------------------
module ray_segment_min_distance_test;
  import rsmd_pkg::*;

  localparam logic [24:0] NO_HIT_DIST = 25'h1FF_FFFF;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        seg_valid;
  logic        seg_stall;
  logic [23:0] seg_ax;
  logic [23:0] seg_ay;
  logic [23:0] seg_bx;
  logic [23:0] seg_by;
  logic        last_segment;
  logic        res_valid;
  logic        res_stall;
  logic [24:0] distance;
  logic        hit_found;

  // predictor copy of the registers and running query state
  logic signed [23:0] ray_ox, ray_oy;
  logic signed [15:0] ray_dx, ray_dy;
  logic [15:0]        zero_eps, slack_tol;
  logic [24:0]        nearest_dist;
  logic               query_hit;

  typedef struct packed {
    logic [24:0] min_dist;
    logic        hit;
  } query_result_t;

  query_result_t expected_results[$];
  int            mismatches;
  int            send_idle_pct;
  int            recv_idle_pct;

  ray_segment_min_distance i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .seg_valid(seg_valid), .seg_stall(seg_stall),
    .seg_ax(seg_ax), .seg_ay(seg_ay), .seg_bx(seg_bx), .seg_by(seg_by),
    .last_segment(last_segment),
    .res_valid(res_valid), .res_stall(res_stall),
    .distance(distance), .hit_found(hit_found)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("** ray_segment_min_distance: FAILED **");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic coef_passes(longint n, logic [63:0] d, logic [63:0] t);
    logic [63:0] x;
    if (n > 0) return 1'b1;
    if (n == 0) return t != 0;
    if (t == 0) return 1'b0;
    x = 64'(-n) * 1024;
    return (x - 1) / t < d;
  endfunction

  function automatic void record_hit(logic [63:0] cand_dist);
    if (cand_dist > 64'(NO_HIT_DIST)) cand_dist = 64'(NO_HIT_DIST);
    if (!query_hit || cand_dist[24:0] < nearest_dist) nearest_dist = cand_dist[24:0];
    query_hit = 1'b1;
  endfunction

  function automatic void predict_segment(logic [23:0] pax, logic [23:0] pay,
                                          logic [23:0] pbx, logic [23:0] pby,
                                          logic plast);
    longint ax, ay, bx, by, det, col, na, nb, s, dxl, dyl;
    logic [63:0] d, c, la, lb, m, q, r, hit_dist, su;
    query_result_t res;
    dxl = ray_dx;
    dyl = ray_dy;
    ax = longint'($signed(pax)) - ray_ox;
    ay = longint'($signed(pay)) - ray_oy;
    bx = longint'($signed(pbx)) - ray_ox;
    by = longint'($signed(pby)) - ray_oy;
    det = ax * by - bx * ay;
    d = det < 0 ? 64'(-det) : 64'(det);
    if (det == 0 || d < 64'(zero_eps)) begin
      col = ax * dyl - dxl * ay;
      c = col < 0 ? 64'(-col) : 64'(col);
      if (col == 0 || c < 64'(zero_eps)) begin
        la = int_sqrt(64'(ax * ax) + 64'(ay * ay));
        lb = int_sqrt(64'(bx * bx) + 64'(by * by));
        record_hit(la < lb ? la : lb);
      end
    end else begin
      na = by * dxl - bx * dyl;
      nb = ax * dyl - ay * dxl;
      if (det < 0) begin
        na = -na;
        nb = -nb;
      end
      if (coef_passes(na, d, 64'(slack_tol)) && coef_passes(nb, d, 64'(slack_tol))) begin
        s = na + nb;
        if (s > 0) begin
          su = 64'(s);
          m = int_sqrt(64'(dxl * dxl) + 64'(dyl * dyl));
          q = d / su;
          r = d % su;
          if (q >= (64'd1 << 25)) hit_dist = 64'(NO_HIT_DIST);
          else hit_dist = q * m + (r * m) / su;
          record_hit(hit_dist);
        end
      end
    end
    if (plast) begin
      res.min_dist = query_hit ? nearest_dist : NO_HIT_DIST;
      res.hit = query_hit;
      expected_results.push_back(res);
      nearest_dist = NO_HIT_DIST;
      query_hit = 1'b0;
    end
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_ORIGIN_X: ray_ox = value[23:0];
      REG_ORIGIN_Y: ray_oy = value[23:0];
      REG_DIR_X:    ray_dx = value[15:0];
      REG_DIR_Y:    ray_dy = value[15:0];
      REG_DET_EPS:  zero_eps = value[15:0];
      REG_COEF_TOL: slack_tol = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_ray(int ox, int oy, int dx, int dy, int eps, int tol);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DET_EPS, eps);
    write_reg(REG_COEF_TOL, tol);
  endtask

  // drain all results and let the last non-emitting segment finish
  task automatic wait_idle();
    int guard;
    guard = 0;
    while (expected_results.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_segment(logic [23:0] ax, logic [23:0] ay, logic [23:0] bx,
                              logic [23:0] by, logic last);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    seg_ax = ax;
    seg_ay = ay;
    seg_bx = bx;
    seg_by = by;
    last_segment = last;
    seg_valid = 1'b1;
    @(posedge clk);
    while (seg_stall) @(posedge clk);
    predict_segment(ax, ay, bx, by, last);
    @(negedge clk);
    seg_valid = 1'b0;
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'(int'($urandom_range(4000)) - 2000);
      2: return 24'(int'($urandom_range(200000)) - 100000);
      default: return $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000;
    endcase
  endfunction

  task automatic test_directed();
    set_ray(0, 0, 16384, 0, 16, 16);
    // wall crossing the ray ahead, another nearer
    send_segment(24'd2560, -24'sd512, 24'd2560, 24'd512, 1'b0);
    send_segment(24'd1280, -24'sd512, 24'd1280, 24'd512, 1'b1);
    // wall behind the ray only
    send_segment(-24'sd1280, -24'sd512, -24'sd1280, 24'd512, 1'b1);
    // collinear degenerate segment on the ray line
    send_segment(24'd300, 24'd0, 24'd900, 24'd0, 1'b1);
    // degenerate but off the ray line
    send_segment(24'd300, 24'd50, 24'd900, 24'd150, 1'b1);
    // identical endpoints
    send_segment(24'd0, 24'd0, 24'd0, 24'd0, 1'b1);
    // field extremes
    send_segment(24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 24'h7F_FFFF, 1'b1);
    send_segment(24'h80_0000, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000, 1'b0);
    send_segment(24'h7F_FFFF, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 1'b1);
    // a segment ending just at the ray, coefficient zero
    send_segment(24'd1000, 24'd0, 24'd1000, 24'd500, 1'b1);
    wait_idle();
    // zero direction, zero tolerance
    set_ray(0, 0, 0, 0, 0, 0);
    send_segment(24'd1000, -24'sd500, 24'd1000, 24'd500, 1'b1);
    send_segment(24'd1000, 24'd0, 24'd1000, 24'd500, 1'b1);
    send_segment(24'd1000, 24'd10, 24'd2000, 24'd20, 1'b1);
    wait_idle();
    // register extremes, wrapping origins
    set_ray(32'h7F_FFFF, 32'h80_0000, 32'hFFFF_C000, 16384, 65535, 65535);
    send_segment(24'h80_0000, 24'h7F_FFFF, 24'd0, 24'd0, 1'b1);
    send_segment(24'd5, 24'd5, 24'd6, 24'd6, 1'b1);
    send_segment(24'h7F_FFFF, 24'h80_0000, 24'h80_0000, 24'h80_0000, 1'b1);
    wait_idle();
  endtask

  task automatic run_random(int count);
    int n;
    logic [23:0] ax, ay, bx, by;
    for (n = 0; n < count; n++) begin
      ax = rand_coord();
      ay = rand_coord();
      case ($urandom_range(4))
        0: begin
          // degenerate: B on the line through origin and A, scaled
          bx = 24'($signed(ax) * 2 - ray_ox);
          by = 24'($signed(ay) * 2 - ray_oy);
        end
        1: begin
          // straddle the ray ahead of the origin
          bx = 24'(ray_ox + (ray_dx >>> 4) * 8 - ($signed(ay) - ray_oy));
          by = 24'(ray_oy + (ray_dy >>> 4) * 8 + ($signed(ax) - ray_ox));
        end
        default: begin
          bx = rand_coord();
          by = rand_coord();
        end
      endcase
      send_segment(ax, ay, bx, by, $urandom_range(3) == 0);
      if (n == count / 2) wait_idle();
    end
    send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b1);
  endtask

  task automatic test_random_phase(int count);
    set_ray($urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
            $urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
            $urandom_range(64), $urandom_range(65535));
    run_random(count);
    wait_idle();
    set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(count / 4);
    wait_idle();
  endtask

  // result checking
  always @(posedge clk) begin
    query_result_t exp_res;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: distance=%0d hit=%0b", distance, hit_found);
      end else begin
        exp_res = expected_results.pop_front();
        if (distance !== exp_res.min_dist || hit_found !== exp_res.hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: distance exp %0d got %0d, hit exp %0b got %0b",
                     exp_res.min_dist, distance, exp_res.hit, hit_found);
        end
      end
    end
  end

  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    seg_valid = 1'b0;
    seg_ax = '0;
    seg_ay = '0;
    seg_bx = '0;
    seg_by = '0;
    last_segment = 1'b0;
    res_stall = 1'b0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    ray_ox = 0;
    ray_oy = 0;
    ray_dx = 16384;
    ray_dy = 0;
    zero_eps = 16;
    slack_tol = 16;
    nearest_dist = NO_HIT_DIST;
    query_hit = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 37;
    recv_idle_pct = 85;
    test_directed();
    test_random_phase(320);
    send_idle_pct = 85;
    recv_idle_pct = 37;
    test_random_phase(320);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase(320);

    wait_idle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** ray_segment_min_distance: PASSED **");
    end else begin
      $display("** ray_segment_min_distance: FAILED **");
    end
    $finish;
  end

endmodule
